// ===== rtl/bcd_rtc_calendar_alarm_assert.svh =====
// Assertion macros for the BCD real-time clock and calendar.
// Included by the top level; needs no package.
`ifndef BCD_RTC_CALENDAR_ALARM_ASSERT_SVH
`define BCD_RTC_CALENDAR_ALARM_ASSERT_SVH

`ifndef ASSERT_OFF

`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define RTC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RTC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rtc_pkg.sv =====
// Types, constants and BCD helper functions of the real-time clock.
// Used by bcd_rtc_calendar_alarm; depends on nothing.
`timescale 1ns / 1ps

package rtc_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        CFG_ALARM_CONTROL = 3'd0,
        CFG_ALARM_SECOND  = 3'd1,
        CFG_ALARM_MINUTE  = 3'd2,
        CFG_ALARM_HOUR    = 3'd3,
        CFG_ALARM_DAY     = 3'd4,
        CFG_ALARM_MONTH   = 3'd5,
        CFG_ALARM_YEAR    = 3'd6
    } cfg_index_t;

    localparam int CFG_DATA_W = 8;

    localparam logic [8:0] SECOND_WRAP = 9'h060;
    localparam logic [8:0] MINUTE_WRAP = 9'h060;
    localparam logic [8:0] HOUR_WRAP   = 9'h024;
    localparam logic [8:0] MONTH_LAST  = 9'h012;
    localparam logic [8:0] YEAR_WRAP   = 9'h100;

    typedef struct packed {
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [2:0] weekday;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
    } rtc_time_t;

    typedef struct packed {
        rtc_time_t  tm;
        logic       alarm_match;
    } rtc_result_t;

    // Adds one to a packed BCD value, carrying into the hundreds bit.
    function automatic logic [8:0] bcd_inc(input logic [7:0] v);
        logic [8:0] s;
        begin
            s = {1'b0, v} + 9'd1;
            if (s[3:0] >= 4'hA)
            begin
                s = s + 9'h006;
            end
            if (s[7:4] >= 4'hA)
            begin
                s = s + 9'h060;
            end
            return s;
        end
    endfunction

    // Month length in BCD; any month other than February or a
    // thirty-day month, including zero and values above twelve, has 31 days.
    function automatic logic [5:0] month_len(input logic [4:0] mon,
                                             input logic [7:0] yr);
        logic [4:0] m;
        logic [7:0] d;
        logic       leap;
        begin
            m    = mon[4] ? (5'd10 + {1'b0, mon[3:0]}) : {1'b0, mon[3:0]};
            d    = {1'b0, yr[7:4], 3'b000} + {3'b000, yr[7:4], 1'b0} + {4'h0, yr[3:0]};
            leap = (d[1:0] == 2'b00) && (d != 8'd100);
            if (m == 5'd2)
            begin
                return leap ? 6'h29 : 6'h28;
            end
            else if (m == 5'd4 || m == 5'd6 || m == 5'd9 || m == 5'd11)
            begin
                return 6'h30;
            end
            else
            begin
                return 6'h31;
            end
        end
    endfunction

    function automatic logic [2:0] weekday_next(input logic [2:0] w);
        begin
            return (w == 3'd7) ? 3'd1 : (w + 3'd1);
        end
    endfunction

endpackage

// ===== rtl/bcd_rtc_calendar_alarm.sv =====
// Top level of the BCD real-time clock and calendar with alarm compare.
// Depends on rtc_pkg and bcd_rtc_calendar_alarm_assert.svh.
`timescale 1ns / 1ps
`include "bcd_rtc_calendar_alarm_assert.svh"

// The block accepts one item, a one-second tick or a load of the whole time,
// on every clock cycle unless the item channel stalls, and returns one result
// per item. The new time and the alarm flag are worked out in a single pass
// of BCD increment and compare logic from the time registers. Results sit in
// an output register backed by one skid register, so the item channel stalls
// only when both hold results that have not been taken. Alarm registers are
// written through the plain write port; writes to unused indexes are ignored.
module bcd_rtc_calendar_alarm
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           operation,
    input  logic [6:0]                     set_second,
    input  logic [6:0]                     set_minute,
    input  logic [5:0]                     set_hour,
    input  logic [2:0]                     set_weekday,
    input  logic [5:0]                     set_day,
    input  logic [4:0]                     set_month,
    input  logic [7:0]                     set_year,

    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [6:0]                     cur_second,
    output logic [6:0]                     cur_minute,
    output logic [5:0]                     cur_hour,
    output logic [2:0]                     cur_weekday,
    output logic [5:0]                     cur_day,
    output logic [4:0]                     cur_month,
    output logic [7:0]                     cur_year,
    output logic                           alarm_match
);

    import rtc_pkg::*;

    logic [6:0]  alarm_control_reg;
    logic [6:0]  alarm_second_reg;
    logic [6:0]  alarm_minute_reg;
    logic [5:0]  alarm_hour_reg;
    logic [5:0]  alarm_day_reg;
    logic [4:0]  alarm_month_reg;
    logic [7:0]  alarm_year_reg;

    rtc_time_t   time_reg;
    rtc_time_t   time_next;
    logic        match_next;

    rtc_result_t out_reg;
    rtc_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    logic        accept;
    logic [8:0]  sec_inc;
    logic [8:0]  min_inc;
    logic [8:0]  hour_inc;
    logic [8:0]  day_inc;
    logic [8:0]  mon_inc;
    logic [8:0]  year_inc;
    logic [5:0]  mon_len;

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_control_reg <= 7'h00;
            alarm_second_reg  <= 7'h00;
            alarm_minute_reg  <= 7'h00;
            alarm_hour_reg    <= 6'h00;
            alarm_day_reg     <= 6'h01;
            alarm_month_reg   <= 5'h01;
            alarm_year_reg    <= 8'h00;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ALARM_CONTROL: alarm_control_reg <= cfg_data[6:0];
                CFG_ALARM_SECOND:  alarm_second_reg  <= cfg_data[6:0];
                CFG_ALARM_MINUTE:  alarm_minute_reg  <= cfg_data[6:0];
                CFG_ALARM_HOUR:    alarm_hour_reg    <= cfg_data[5:0];
                CFG_ALARM_DAY:     alarm_day_reg     <= cfg_data[5:0];
                CFG_ALARM_MONTH:   alarm_month_reg   <= cfg_data[4:0];
                CFG_ALARM_YEAR:    alarm_year_reg    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // On a tick, each field only moves when every field below it has wrapped.
    always_comb
    begin
        sec_inc   = bcd_inc({1'b0, time_reg.second});
        min_inc   = bcd_inc({1'b0, time_reg.minute});
        hour_inc  = bcd_inc({2'b00, time_reg.hour});
        day_inc   = bcd_inc({2'b00, time_reg.day});
        mon_inc   = bcd_inc({3'b000, time_reg.month});
        year_inc  = bcd_inc(time_reg.year);
        mon_len   = month_len(time_reg.month, time_reg.year);
        time_next = time_reg;

        if (operation == OP_LOAD)
        begin
            time_next.second  = set_second;
            time_next.minute  = set_minute;
            time_next.hour    = set_hour;
            time_next.weekday = set_weekday;
            time_next.day     = set_day;
            time_next.month   = set_month;
            time_next.year    = set_year;
        end
        else if (sec_inc < SECOND_WRAP)
        begin
            time_next.second = sec_inc[6:0];
        end
        else
        begin
            time_next.second = 7'h00;
            if (min_inc < MINUTE_WRAP)
            begin
                time_next.minute = min_inc[6:0];
            end
            else
            begin
                time_next.minute = 7'h00;
                if (hour_inc < HOUR_WRAP)
                begin
                    time_next.hour = hour_inc[5:0];
                end
                else
                begin
                    time_next.hour    = 6'h00;
                    time_next.weekday = weekday_next(time_reg.weekday);
                    if (day_inc <= {3'b000, mon_len})
                    begin
                        time_next.day = day_inc[5:0];
                    end
                    else
                    begin
                        time_next.day = 6'h01;
                        if (mon_inc <= MONTH_LAST)
                        begin
                            time_next.month = mon_inc[4:0];
                        end
                        else
                        begin
                            time_next.month = 5'h01;
                            time_next.year  = (year_inc >= YEAR_WRAP) ? 8'h00
                                                                      : year_inc[7:0];
                        end
                    end
                end
            end
        end

        match_next = alarm_control_reg[6]
            && (!alarm_control_reg[5] || alarm_year_reg   == time_next.year)
            && (!alarm_control_reg[4] || alarm_month_reg  == time_next.month)
            && (!alarm_control_reg[3] || alarm_day_reg    == time_next.day)
            && (!alarm_control_reg[2] || alarm_hour_reg   == time_next.hour)
            && (!alarm_control_reg[1] || alarm_minute_reg == time_next.minute)
            && (!alarm_control_reg[0] || alarm_second_reg == time_next.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (accept)
        begin
            time_reg <= time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || !result_stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && !result_stall)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || !result_stall)
            begin
                out_reg <= '{tm: time_next, alarm_match: match_next};
            end
            else
            begin
                skid_reg <= '{tm: time_next, alarm_match: match_next};
            end
        end
        else if (out_valid_reg && !result_stall && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign cur_second   = out_reg.tm.second;
    assign cur_minute   = out_reg.tm.minute;
    assign cur_hour     = out_reg.tm.hour;
    assign cur_weekday  = out_reg.tm.weekday;
    assign cur_day      = out_reg.tm.day;
    assign cur_month    = out_reg.tm.month;
    assign cur_year     = out_reg.tm.year;
    assign alarm_match  = out_reg.alarm_match;

    `RTC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `RTC_ASSERT_NXT(a_free_out_fills, clk, rst_n, accept && !out_valid_reg, out_valid_reg)
    `RTC_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_reg && !result_stall, !skid_valid_reg)
    `RTC_ASSERT_NXT(a_tick_in_range, clk, rst_n, accept && operation == OP_TICK, time_reg.second < 7'h60)

endmodule
